/* sv/sine_cosine_table_interpolator_core_macros.svh */
// ----------------------------------------------------------------------------
// Sine/cosine interpolator assertion macros
// Shared concurrent assertion shorthands for the interpolator core.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define SINE_COSINE_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define SCTI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scti assertion failed");

// Next-cycle implication, checked only outside reset.
`define SCTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scti assertion failed");

// Next-cycle implication that is also checked while reset is applied.
`define SCTI_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scti assertion failed");

`endif

/* sv/scti_pkg.sv */
// ----------------------------------------------------------------------------
// Sine/cosine interpolator package
// Shared constants and the elaboration-time quarter-wave amplitude table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scti_pkg;

  localparam int PHASE_W           = 16;
  localparam int VALUE_W           = 16;
  localparam int STEP_W            = 8;
  localparam int QUARTER_LEN       = 65;
  localparam int IDX_W             = $clog2(QUARTER_LEN);
  localparam int AMP_W_MAX         = 21;
  localparam int DEF_FRAC_BITS     = 8;
  localparam int DEF_AMP_FRAC_BITS = 14;

  localparam logic [STEP_W-1:0] QUARTER_STEPS = 8'd64;
  localparam logic [STEP_W-1:0] HALF_STEPS    = 8'd128;
  localparam logic [STEP_W-1:0] Q2_LAST       = 8'd128;
  localparam logic [STEP_W-1:0] Q3_LAST       = 8'd192;
  localparam logic [STEP_W:0]   FULL_TURN     = 9'd256;

  localparam longint MICRO_SCALE = 64'd1000000;
  localparam longint HALF_MICRO  = 64'd500000;

  typedef logic [AMP_W_MAX-1:0] amp_table_t [QUARTER_LEN];

  // Quarter-wave sine in millionths, entries 0 through 64.
  function automatic logic [19:0] quarter_micro(input int idx);
    logic [19:0] m;
    case (idx)
      0:  m = 20'd0;       1:  m = 20'd24541;   2:  m = 20'd49068;   3:  m = 20'd73565;
      4:  m = 20'd98017;   5:  m = 20'd122411;  6:  m = 20'd146730;  7:  m = 20'd170962;
      8:  m = 20'd195090;  9:  m = 20'd219101;  10: m = 20'd242980;  11: m = 20'd266713;
      12: m = 20'd290285;  13: m = 20'd313682;  14: m = 20'd336890;  15: m = 20'd359895;
      16: m = 20'd382683;  17: m = 20'd405241;  18: m = 20'd427555;  19: m = 20'd449611;
      20: m = 20'd471397;  21: m = 20'd492898;  22: m = 20'd514103;  23: m = 20'd534998;
      24: m = 20'd555570;  25: m = 20'd575808;  26: m = 20'd595699;  27: m = 20'd615232;
      28: m = 20'd634393;  29: m = 20'd653173;  30: m = 20'd671559;  31: m = 20'd689541;
      32: m = 20'd707107;  33: m = 20'd724247;  34: m = 20'd740951;  35: m = 20'd757209;
      36: m = 20'd773010;  37: m = 20'd788346;  38: m = 20'd803208;  39: m = 20'd817585;
      40: m = 20'd831470;  41: m = 20'd844854;  42: m = 20'd857729;  43: m = 20'd870087;
      44: m = 20'd881921;  45: m = 20'd893224;  46: m = 20'd903989;  47: m = 20'd914210;
      48: m = 20'd923880;  49: m = 20'd932993;  50: m = 20'd941544;  51: m = 20'd949528;
      52: m = 20'd956940;  53: m = 20'd963776;  54: m = 20'd970031;  55: m = 20'd975702;
      56: m = 20'd980785;  57: m = 20'd985278;  58: m = 20'd989177;  59: m = 20'd992480;
      60: m = 20'd995185;  61: m = 20'd997290;  62: m = 20'd998795;  63: m = 20'd999699;
      64: m = 20'd1000000;
      default: m = 20'd0;
    endcase
    return m;
  endfunction

  // Scales each entry by 2^amp_bits and rounds half up; evaluated at elaboration.
  function automatic amp_table_t build_amp_table(input int amp_bits);
    amp_table_t tab;
    longint     m;
    longint     scaled;
    for (int i = 0; i < QUARTER_LEN; i++) begin
      m      = longint'(quarter_micro(i));
      scaled = (m <<< amp_bits) + HALF_MICRO;
      tab[i] = AMP_W_MAX'(scaled / MICRO_SCALE);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

/* sv/scti_phase_decode.sv */
// ----------------------------------------------------------------------------
// Phase decode stage
// Splits the phase into table step and fraction and applies the cosine shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scti_phase_decode
  import scti_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  input  wire logic [PHASE_W-1:0] in_phase,
  output logic                    v1_valid,
  output logic [STEP_W-1:0]       v1_step_a,
  output logic [STEP_W-1:0]       v1_step_b,
  output logic [FW-1:0]           v1_frac
);

  localparam logic [PHASE_W-1:0] FRAC_MASK = PHASE_W'((1 << FRAC_BITS) - 1);

  logic                       valid_r;
  logic [STEP_W-1:0]          step_a_r, step_a_nxt;
  logic [STEP_W-1:0]          step_b_r, step_b_nxt;
  logic [FW-1:0]              frac_r, frac_nxt;
  logic [PHASE_W+STEP_W-1:0]  ph_shift;
  logic [STEP_W-1:0]          step_raw;

  always_comb begin
    ph_shift   = {{STEP_W{1'b0}}, in_phase} >> FRAC_BITS;
    step_raw   = ph_shift[STEP_W-1:0];
    // Cosine is sine a quarter turn earlier; the 8-bit step wraps.
    step_a_nxt = in_cmd ? STEP_W'(step_raw - QUARTER_STEPS) : step_raw;
    step_b_nxt = STEP_W'(step_a_nxt + 1'b1);
    frac_nxt   = FW'(in_phase & FRAC_MASK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_a_r <= step_a_nxt;
      step_b_r <= step_b_nxt;
      frac_r   <= frac_nxt;
    end
  end

  assign v1_valid  = valid_r;
  assign v1_step_a = step_a_r;
  assign v1_step_b = step_b_r;
  assign v1_frac   = frac_r;

endmodule

`default_nettype wire

/* sv/scti_quadrant_lookup.sv */
// ----------------------------------------------------------------------------
// Quadrant lookup stage
// Reads both neighboring samples from the quarter-wave table with mirroring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scti_quadrant_lookup
  import scti_pkg::*;
#(
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS,
  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1,
  localparam int SW = AMP_FRAC_BITS + 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              v1_valid,
  input  wire logic [STEP_W-1:0] v1_step_a,
  input  wire logic [STEP_W-1:0] v1_step_b,
  input  wire logic [FW-1:0]     v1_frac,
  output logic                   v2_valid,
  output logic signed [SW-1:0]   v2_s1,
  output logic signed [SW-1:0]   v2_s2,
  output logic [FW-1:0]          v2_frac
);

  localparam int         AW      = AMP_FRAC_BITS + 1;
  localparam amp_table_t AMP_TAB = build_amp_table(AMP_FRAC_BITS);

  logic                 valid_r;
  logic signed [SW-1:0] s1_r, s1_nxt;
  logic signed [SW-1:0] s2_r, s2_nxt;
  logic [FW-1:0]        frac_r;

  // Mirrors the step into the first quadrant and negates the lower half-wave.
  function automatic logic signed [SW-1:0] wave_at(input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] folded;
    logic              neg;
    logic [AW-1:0]     mag;
    logic [IDX_W-1:0]  idx;
    folded = step;
    neg    = 1'b0;
    case (step) inside
      [8'd0 : QUARTER_STEPS]: begin
        folded = step;
      end
      [QUARTER_STEPS + 8'd1 : Q2_LAST]: begin
        folded = STEP_W'(HALF_STEPS - step);
      end
      [Q2_LAST + 8'd1 : Q3_LAST]: begin
        folded = STEP_W'(step - HALF_STEPS);
        neg    = 1'b1;
      end
      default: begin
        folded = STEP_W'(FULL_TURN - {1'b0, step});
        neg    = 1'b1;
      end
    endcase
    idx = folded[IDX_W-1:0];
    mag = AMP_TAB[idx][AW-1:0];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  always_comb begin
    s1_nxt = wave_at(v1_step_a);
    s2_nxt = wave_at(v1_step_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      frac_r <= v1_frac;
    end
  end

  assign v2_valid = valid_r;
  assign v2_s1    = s1_r;
  assign v2_s2    = s2_r;
  assign v2_frac  = frac_r;

endmodule

`default_nettype wire

/* sv/scti_interp.sv */
// ----------------------------------------------------------------------------
// Linear interpolation stages
// Difference, fraction multiply, and flooring shift-add into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scti_interp
  import scti_pkg::*;
#(
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS,
  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1,
  localparam int SW = AMP_FRAC_BITS + 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               v2_valid,
  input  wire logic signed [SW-1:0] v2_s1,
  input  wire logic signed [SW-1:0] v2_s2,
  input  wire logic [FW-1:0]      v2_frac,
  output logic                    out_valid,
  output logic [VALUE_W-1:0]      out_value
);

  localparam int DW = SW + 1;
  localparam int PW = FW + 1 + DW;
  localparam int XW = (PW > VALUE_W) ? PW : VALUE_W;

  // Stage 3: difference of neighbors.
  logic                 v3_valid_r;
  logic signed [DW-1:0] diff_r, diff_nxt;
  logic signed [SW-1:0] s1_d3_r;
  logic [FW-1:0]        frac_d3_r;

  // Stage 4: fraction times difference.
  logic                 v4_valid_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [SW-1:0] s1_d4_r;

  // Stage 5: output register.
  logic                 v5_valid_r;
  logic signed [XW-1:0] sum_nxt;
  logic [VALUE_W-1:0]   value_r;

  always_comb begin
    diff_nxt = DW'(v2_s2) - DW'(v2_s1);
    prod_nxt = PW'($signed({1'b0, frac_d3_r})) * PW'(diff_r);
    // Arithmetic shift of the exact product floors toward minus infinity.
    sum_nxt  = XW'(s1_d4_r) + XW'(prod_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_valid_r <= 1'b0;
      v4_valid_r <= 1'b0;
      v5_valid_r <= 1'b0;
    end else if (adv) begin
      v3_valid_r <= v2_valid;
      v4_valid_r <= v3_valid_r;
      v5_valid_r <= v4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r    <= diff_nxt;
      s1_d3_r   <= v2_s1;
      frac_d3_r <= v2_frac;
      prod_r    <= prod_nxt;
      s1_d4_r   <= s1_d3_r;
      value_r   <= sum_nxt[VALUE_W-1:0];
    end
  end

  assign out_valid = v5_valid_r;
  assign out_value = value_r;

endmodule

`default_nettype wire

/* sv/sine_cosine_table_interpolator_core.sv */
// Stages: decode, lookup, difference, product and output register, in that order.
// Throughput: one item per cycle unless the output stalls; the five-stage pipeline advances as a whole.
// A stalled output register freezes every stage; in_ready follows out_ready then.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator core
// Quarter-wave table sine and cosine with linear interpolation between steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sine_cosine_table_interpolator_core_macros.svh"

module sine_cosine_table_interpolator_core
  import scti_pkg::*;
#(
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic [PHASE_W-1:0] in_phase,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [VALUE_W-1:0]      out_value
);

  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int SW = AMP_FRAC_BITS + 2;

  // The whole pipeline moves forward whenever the output register is empty or
  // its result is transferred in this cycle. Every stage shares this enable,
  // so a stall holds each item in place and nothing is dropped or repeated.
  logic adv;

  logic                 v1_valid;
  logic [STEP_W-1:0]    v1_step_a;
  logic [STEP_W-1:0]    v1_step_b;
  logic [FW-1:0]        v1_frac;

  logic                 v2_valid;
  logic signed [SW-1:0] v2_s1;
  logic signed [SW-1:0] v2_s2;
  logic [FW-1:0]        v2_frac;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: step and fraction extraction, cosine quarter-turn shift, and
  // the following step for interpolation (step 255 wraps to step 0).
  scti_phase_decode #(
    .FRAC_BITS (FRAC_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_phase  (in_phase),
    .v1_valid  (v1_valid),
    .v1_step_a (v1_step_a),
    .v1_step_b (v1_step_b),
    .v1_frac   (v1_frac)
  );

  // Stage 2: two reads of the 65-entry constant table with quadrant folding.
  scti_quadrant_lookup #(
    .FRAC_BITS     (FRAC_BITS),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .v1_valid  (v1_valid),
    .v1_step_a (v1_step_a),
    .v1_step_b (v1_step_b),
    .v1_frac   (v1_frac),
    .v2_valid  (v2_valid),
    .v2_s1     (v2_s1),
    .v2_s2     (v2_s2),
    .v2_frac   (v2_frac)
  );

  // Stages 3 to 5: difference, one narrow multiply, then the flooring shift
  // and add that lands in the output register.
  scti_interp #(
    .FRAC_BITS     (FRAC_BITS),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .v2_valid  (v2_valid),
    .v2_s1     (v2_s1),
    .v2_s2     (v2_s2),
    .v2_frac   (v2_frac),
    .out_valid (out_valid),
    .out_value (out_value)
  );

  // While the pipeline is frozen, no stage may gain or lose an item.
  `SCTI_ASSERT_NEXT(a_stall_holds_valids, !adv, $stable({v1_valid, v2_valid, out_valid}))

  // Reset empties the pipeline, including the output register.
  `SCTI_ASSERT_NEXT_ALWAYS(a_reset_empties, !rst_n, !out_valid && !v1_valid && !v2_valid)

  // When the amplitude fits the output word, every result stays within unit scale.
  `SCTI_ASSERT_IMPL(a_value_in_range, out_valid && (AMP_FRAC_BITS <= 14), (int'($signed(out_value)) <= (1 << AMP_FRAC_BITS)) && (int'($signed(out_value)) >= -(1 << AMP_FRAC_BITS)))

endmodule

`default_nettype wire

/* test/tb_sine_cosine_table_interpolator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine table interpolator testbench
// Self-checking bench. Phases are pushed through a valid/ready channel with
// random gaps. Results are drained with random back-pressure. Each result is
// compared against a bench-side quarter-wave interpolation predictor.
// ----------------------------------------------------------------------------

module tb_sine_cosine_table_interpolator_core;
  import scti_pkg::*;

  localparam int FRAC_W     = 8;    // fraction bits below the table step
  localparam int AMP_FRAC_W = 14;   // 1 << AMP_FRAC_W stands for an amplitude of 1.0
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 8;     // comfortably past the five-stage latency
  localparam int WATCHDOG_LIMIT = 1000;  // far above the longest legal quiet stretch
  localparam int RANDOM_ITEMS   = 1830;
  localparam int MAX_WAIT       = 19;
  localparam int REPORT_LIMIT   = 10;

  // Function select carried on in_cmd.
  typedef enum logic {
    FUNC_SIN = 1'b0,
    FUNC_COS = 1'b1
  } func_sel_t;

  typedef struct packed {
    func_sel_t            func;
    logic [PHASE_W-1:0]   phase;
  } phase_req_t;

  typedef struct {
    phase_req_t           req;
    logic [VALUE_W-1:0]   value;
  } expected_value_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               in_cmd    = 1'b0;
  logic [PHASE_W-1:0] in_phase  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] out_value;

  always #5 clk = ~clk;

  sine_cosine_table_interpolator_core #(
    .FRAC_BITS     (FRAC_W),
    .AMP_FRAC_BITS (AMP_FRAC_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_phase  (in_phase),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  // --------------------------------------------------------------------------
  // Predictor. The quarter-wave sine is held in millionths and scaled to the
  // amplitude format with round-half-up, just like the table in the core is
  // meant to be. Other quadrants are reached by mirroring and negation.
  // --------------------------------------------------------------------------
  int unsigned quarter_sine_ppm [QUARTER_LEN] = '{
    0, 24541, 49068, 73565, 98017, 122411, 146730, 170962,
    195090, 219101, 242980, 266713, 290285, 313682, 336890, 359895,
    382683, 405241, 427555, 449611, 471397, 492898, 514103, 534998,
    555570, 575808, 595699, 615232, 634393, 653173, 671559, 689541,
    707107, 724247, 740951, 757209, 773010, 788346, 803208, 817585,
    831470, 844854, 857729, 870087, 881921, 893224, 903989, 914210,
    923880, 932993, 941544, 949528, 956940, 963776, 970031, 975702,
    980785, 985278, 989177, 992480, 995185, 997290, 998795, 999699,
    1000000
  };

  function automatic longint quarter_amp(input int unsigned idx);
    longint ppm;
    ppm = longint'(quarter_sine_ppm[idx]);
    return ((ppm <<< AMP_FRAC_W) + HALF_MICRO) / MICRO_SCALE;
  endfunction

  // Full-turn sine sample at a table step.
  function automatic longint wave_sample(input logic [STEP_W-1:0] step);
    int unsigned s;
    s = step;
    if (s <= QUARTER_STEPS)
      return quarter_amp(s);
    else if (s <= HALF_STEPS)
      return quarter_amp(HALF_STEPS - s);
    else if (s <= Q3_LAST)
      return -quarter_amp(s - HALF_STEPS);
    else
      return -quarter_amp(FULL_TURN - s);
  endfunction

  // Interpolated sine or cosine for one phase. Cosine reads the table one
  // quarter turn earlier; step 255 interpolates toward step 0 by 8-bit wrap.
  // The weighted difference is floored by an arithmetic right shift.
  function automatic logic [VALUE_W-1:0] interp_value(input phase_req_t req);
    logic [STEP_W-1:0] step;
    longint            frac;
    longint            s1;
    longint            s2;
    longint            sum;
    step = req.phase[FRAC_W +: STEP_W];
    frac = longint'(req.phase[FRAC_W-1:0]);
    if (req.func == FUNC_COS)
      step = step - QUARTER_STEPS;
    s1  = wave_sample(step);
    s2  = wave_sample(step + 1'b1);
    sum = s1 + ((frac * (s2 - s1)) >>> FRAC_W);
    return sum[VALUE_W-1:0];
  endfunction

  // Idle length between transfers. A calm stretch has no idling at all.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard state.
  // --------------------------------------------------------------------------
  phase_req_t      pending_phases [$];
  expected_value_t expected_values [$];
  int              mismatch_count = 0;
  int              sin_checked    = 0;
  int              cos_checked    = 0;

  // --------------------------------------------------------------------------
  // Driver. On every input transfer the expected value is predicted and
  // queued, then a fresh gap is drawn. Valid is held with a stable payload
  // until the transfer happens; each port is assigned once per edge.
  // --------------------------------------------------------------------------
  int  in_gap  = 0;
  bit  in_calm = 1'b0;

  always @(posedge clk) begin
    expected_value_t exp_item;
    phase_req_t      sent_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent_req.func  = func_sel_t'(in_cmd);
        sent_req.phase = in_phase;
        exp_item.req   = sent_req;
        exp_item.value = interp_value(sent_req);
        expected_values.push_back(exp_item);
        void'(pending_phases.pop_front());
        if ($urandom_range(0, 39) == 0)
          in_calm = !in_calm;
        in_gap = draw_wait(in_calm);
      end
      if (in_valid && !in_ready) begin
        // Still waiting for the current transfer: keep everything as is.
      end else if (in_gap > 0) begin
        in_gap   = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_phases.size() > 0) begin
        in_valid <= 1'b1;
        in_cmd   <= pending_phases[0].func;
        in_phase <= pending_phases[0].phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Ready is dropped for a random stall after each result transfer.
  // Every result is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  int  out_stall = 0;
  bit  out_calm  = 1'b0;

  always @(posedge clk) begin
    expected_value_t exp_item;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: result %0d arrived with no phase outstanding",
                     $signed(out_value));
        end else begin
          exp_item = expected_values.pop_front();
          if (exp_item.req.func == FUNC_COS)
            cos_checked++;
          else
            sin_checked++;
          if (out_value !== exp_item.value) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("ERROR: %s phase 0x%04h expected %0d got %0d",
                       exp_item.req.func.name(), exp_item.req.phase,
                       $signed(exp_item.value), $signed(out_value));
          end
        end
        if ($urandom_range(0, 39) == 0)
          out_calm = !out_calm;
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no transfer on either side means the
  // core has hung.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  task automatic add_phase(input func_sel_t func, input logic [PHASE_W-1:0] phase);
    phase_req_t req;
    req.func  = func;
    req.phase = phase;
    pending_phases.push_back(req);
  endtask

  initial begin
    logic [STEP_W-1:0] edge_steps [12];
    logic [STEP_W-1:0] step;
    logic [PHASE_W-1:0] phase;
    int leftover;

    edge_steps = '{
      8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd127,
      8'd128, 8'd129, 8'd191, 8'd192, 8'd193, 8'd255
    };

    // Directed part: phase extremes, the quadrant boundaries, the largest
    // fraction, the step-255 wrap for both functions and the quarter-turn
    // shift of cosine wrapping below step zero.
    add_phase(FUNC_SIN, 16'h0000);
    add_phase(FUNC_COS, 16'h0000);
    add_phase(FUNC_SIN, 16'hFFFF);
    add_phase(FUNC_COS, 16'hFFFF);
    add_phase(FUNC_SIN, 16'h00FF);
    add_phase(FUNC_SIN, 16'hFF80);
    add_phase(FUNC_COS, 16'h3F80);
    add_phase(FUNC_SIN, 16'h4000);
    add_phase(FUNC_COS, 16'h4000);
    add_phase(FUNC_SIN, 16'h4080);
    add_phase(FUNC_SIN, 16'h8000);
    add_phase(FUNC_COS, 16'h8000);
    add_phase(FUNC_SIN, 16'h80FF);
    add_phase(FUNC_SIN, 16'hC000);
    add_phase(FUNC_COS, 16'hC000);
    add_phase(FUNC_SIN, 16'hC0FF);
    add_phase(FUNC_SIN, 16'h3FFF);
    add_phase(FUNC_COS, 16'h3FFF);
    add_phase(FUNC_SIN, 16'h5555);
    add_phase(FUNC_COS, 16'hAAAA);
    add_phase(FUNC_SIN, 16'h7F01);
    add_phase(FUNC_COS, 16'hBF7F);

    // Random part: mostly uniform phases, with a share aimed at the steps
    // around the quadrant seams where mirroring and negation switch over.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = PHASE_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        step  = edge_steps[$urandom_range(0, 11)];
        phase[FRAC_W +: STEP_W] = step;
      end
      add_phase(func_sel_t'($urandom_range(0, 1)), phase);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so queue updates made at the rising edge
    // have settled.
    do
      @(negedge clk);
    while (pending_phases.size() != 0 || in_valid || expected_values.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    leftover = expected_values.size();
    if (leftover != 0) begin
      mismatch_count += leftover;
      $display("ERROR: %0d expected results never arrived", leftover);
    end
    $display("Checked %0d sine and %0d cosine results across the full phase range,",
             sin_checked, cos_checked);
    $display("including quadrant seams, the step-255 wrap and random flow control.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
